// File: rtl/hctn_pkg.sv
// ----------------------------------------------------------------------------
// hctn_pkg
// Shared types and constants of the toolpath height clamp and thinning block.
// ----------------------------------------------------------------------------
package hctn_pkg;

   localparam int VAL_BITS     = 32;
   localparam int TOL_BITS     = 31;
   localparam int CSR_IDX_BITS = 3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_BASE_HEIGHT = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOLERANCE   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCALE_X     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OFFSET_X    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCALE_Y     = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OFFSET_Y    = 3'd5;

   typedef struct packed {
      logic item_last;
      logic path_end;
   } pt_flags_type;

endpackage

// File: rtl/hctn_decide.sv
// ----------------------------------------------------------------------------
// hctn_decide
// Thinning decision and path state; issues one point per cycle, unless held
// by pt_ready, into a registered point stage.
// ----------------------------------------------------------------------------
module hctn_decide #(
   parameter int COORD_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_take,
   input  logic signed [COORD_BITS-1:0]       in_tx,
   input  logic signed [COORD_BITS-1:0]       in_ty,
   input  logic signed [hctn_pkg::VAL_BITS-1:0] in_height,
   input  logic                               in_last,
   input  logic signed [hctn_pkg::VAL_BITS-1:0] base_height,
   input  logic [hctn_pkg::TOL_BITS-1:0]      tolerance,
   output logic                               pt_valid,
   input  logic                               pt_ready,
   output logic signed [COORD_BITS-1:0]       pt_tx,
   output logic signed [COORD_BITS-1:0]       pt_ty,
   output logic signed [hctn_pkg::VAL_BITS-1:0] pt_height,
   output hctn_pkg::pt_flags_type             pt_flags
);
   import hctn_pkg::*;

   localparam int DIR_BITS = COORD_BITS + 1;

   logic signed [COORD_BITS-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [DIR_BITS-1:0]   dir_x_ff, dir_x_in, dir_y_ff, dir_y_in;
   logic signed [VAL_BITS-1:0]   emit_h_ff, emit_h_in;
   logic                         started_ff, started_in;
   logic                         phase_ff, phase_in;

   logic                         pt_v_ff;
   logic signed [COORD_BITS-1:0] pt_tx_ff, pt_ty_ff;
   logic signed [VAL_BITS-1:0]   pt_h_ff;
   pt_flags_type                 pt_flags_ff;

   logic signed [DIR_BITS-1:0]   dx, dy;
   logic signed [VAL_BITS:0]     diff;
   logic [VAL_BITS:0]            mag;
   logic                         c_first, c_base, c_dir, c_dev, has1;
   logic                         emit_any, emit_end, out_rdy, step;
   logic signed [COORD_BITS-1:0] sel_x, sel_y;
   logic signed [VAL_BITS-1:0]   sel_h;

   always_comb begin
      dx   = {in_tx[COORD_BITS-1], in_tx} - {prev_x_ff[COORD_BITS-1], prev_x_ff};
      dy   = {in_ty[COORD_BITS-1], in_ty} - {prev_y_ff[COORD_BITS-1], prev_y_ff};
      diff = {in_height[VAL_BITS-1], in_height} - {emit_h_ff[VAL_BITS-1], emit_h_ff};
      mag  = diff[VAL_BITS] ? (VAL_BITS+1)'(-diff) : diff;

      c_first = !started_ff;
      c_base  = (in_height == base_height) && (in_height != emit_h_ff);
      c_dir   = (dx != dir_x_ff) || (dy != dir_y_ff);
      c_dev   = {mag, 1'b0} > {3'b000, tolerance};
      has1    = c_first || c_base || c_dir || c_dev;

      // previous point at base height on a direction change
      if (!c_first && !c_base && c_dir) begin
         sel_x = prev_x_ff;
         sel_y = prev_y_ff;
         sel_h = base_height;
      end else begin
         sel_x = in_tx;
         sel_y = in_ty;
         sel_h = in_height;
      end

      emit_end = phase_ff || (in_last && !has1);
      emit_any = phase_ff || has1 || in_last;
      out_rdy  = !pt_v_ff || pt_ready;
      step     = in_valid && (out_rdy || !emit_any);
      in_take  = step && (phase_ff || !(has1 && in_last));

      phase_in = phase_ff;
      if (step && !phase_ff && has1 && in_last) begin
         phase_in = 1'b1;
      end else if (in_take) begin
         phase_in = 1'b0;
      end

      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      dir_x_in   = dir_x_ff;
      dir_y_in   = dir_y_ff;
      emit_h_in  = emit_h_ff;
      started_in = started_ff;
      if (step && !phase_ff) begin
         if (in_last) begin
            prev_x_in  = '0;
            prev_y_in  = '0;
            dir_x_in   = '0;
            dir_y_in   = '0;
            emit_h_in  = '0;
            started_in = 1'b0;
         end else begin
            prev_x_in  = in_tx;
            prev_y_in  = in_ty;
            dir_x_in   = dx;
            dir_y_in   = dy;
            started_in = 1'b1;
            if (has1) begin
               emit_h_in = sel_h;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
         dir_x_ff   <= '0;
         dir_y_ff   <= '0;
         emit_h_ff  <= '0;
         started_ff <= 1'b0;
         phase_ff   <= 1'b0;
         pt_v_ff    <= 1'b0;
      end else begin
         prev_x_ff  <= prev_x_in;
         prev_y_ff  <= prev_y_in;
         dir_x_ff   <= dir_x_in;
         dir_y_ff   <= dir_y_in;
         emit_h_ff  <= emit_h_in;
         started_ff <= started_in;
         phase_ff   <= phase_in;
         if (out_rdy) begin
            pt_v_ff <= in_valid && emit_any;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy && in_valid && emit_any) begin
         if (emit_end) begin
            pt_tx_ff    <= in_tx;
            pt_ty_ff    <= in_ty;
            pt_h_ff     <= base_height;
            pt_flags_ff <= '{item_last: 1'b1, path_end: 1'b1};
         end else begin
            pt_tx_ff    <= sel_x;
            pt_ty_ff    <= sel_y;
            pt_h_ff     <= sel_h;
            pt_flags_ff <= '{item_last: !in_last, path_end: 1'b0};
         end
      end
   end

   assign pt_valid  = pt_v_ff;
   assign pt_tx     = pt_tx_ff;
   assign pt_ty     = pt_ty_ff;
   assign pt_height = pt_h_ff;
   assign pt_flags  = pt_flags_ff;

endmodule

// File: rtl/hctn_xform.sv
// ----------------------------------------------------------------------------
// hctn_xform
// Texel to block unit conversion: registered scale multiply, then offset
// subtract with saturation into the result register.
// ----------------------------------------------------------------------------
module hctn_xform #(
   parameter int COORD_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 pt_valid,
   output logic                                 pt_ready,
   input  logic signed [COORD_BITS-1:0]         pt_tx,
   input  logic signed [COORD_BITS-1:0]         pt_ty,
   input  logic signed [hctn_pkg::VAL_BITS-1:0] pt_height,
   input  hctn_pkg::pt_flags_type               pt_flags,
   input  logic [hctn_pkg::VAL_BITS-1:0]        scale_x,
   input  logic signed [hctn_pkg::VAL_BITS-1:0] offset_x,
   input  logic [hctn_pkg::VAL_BITS-1:0]        scale_y,
   input  logic signed [hctn_pkg::VAL_BITS-1:0] offset_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [hctn_pkg::VAL_BITS-1:0] rsp_out_x,
   output logic signed [hctn_pkg::VAL_BITS-1:0] rsp_out_z,
   output logic signed [hctn_pkg::VAL_BITS-1:0] rsp_out_height,
   output logic                                 rsp_item_last,
   output logic                                 rsp_path_end
);
   import hctn_pkg::*;

   localparam int PROD_BITS = COORD_BITS + VAL_BITS + 1;
   localparam int SUM_BITS  = PROD_BITS + 1;

   logic                        a_v_ff, b_v_ff, a_rdy, b_rdy;
   logic signed [PROD_BITS-1:0] px_ff, pz_ff;
   logic signed [VAL_BITS-1:0]  a_h_ff, b_x_ff, b_z_ff, b_h_ff;
   pt_flags_type                a_flags_ff, b_flags_ff;
   logic signed [SUM_BITS-1:0]  sx, sz;

   function automatic logic signed [VAL_BITS-1:0] sat_val(
      input logic signed [SUM_BITS-1:0] v
   );
      logic ovf;
      ovf = (v[SUM_BITS-1:VAL_BITS-1] != {(SUM_BITS-VAL_BITS+1){v[SUM_BITS-1]}});
      if (!ovf) begin
         sat_val = v[VAL_BITS-1:0];
      end else if (v[SUM_BITS-1]) begin
         sat_val = {1'b1, {(VAL_BITS-1){1'b0}}};
      end else begin
         sat_val = {1'b0, {(VAL_BITS-1){1'b1}}};
      end
   endfunction

   assign b_rdy    = !b_v_ff || rsp_ready;
   assign a_rdy    = !a_v_ff || b_rdy;
   assign pt_ready = a_rdy;

   always_comb begin
      sx = {px_ff[PROD_BITS-1], px_ff} - SUM_BITS'(offset_x);
      sz = {pz_ff[PROD_BITS-1], pz_ff} - SUM_BITS'(offset_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else begin
         if (a_rdy) begin
            a_v_ff <= pt_valid;
         end
         if (b_rdy) begin
            b_v_ff <= a_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_rdy && pt_valid) begin
         px_ff      <= PROD_BITS'(pt_tx) * $signed({1'b0, scale_x});
         pz_ff      <= PROD_BITS'(pt_ty) * $signed({1'b0, scale_y});
         a_h_ff     <= pt_height;
         a_flags_ff <= pt_flags;
      end
      if (b_rdy && a_v_ff) begin
         b_x_ff     <= sat_val(sx);
         b_z_ff     <= sat_val(sz);
         b_h_ff     <= a_h_ff;
         b_flags_ff <= a_flags_ff;
      end
   end

   assign rsp_valid      = b_v_ff;
   assign rsp_out_x      = b_x_ff;
   assign rsp_out_z      = b_z_ff;
   assign rsp_out_height = b_h_ff;
   assign rsp_item_last  = b_flags_ff.item_last;
   assign rsp_path_end   = b_flags_ff.path_end;

endmodule

// File: rtl/toolpath_height_clamp_thinning.sv
// ----------------------------------------------------------------------------
// toolpath_height_clamp_thinning
// Clamps raster toolpath point heights, thins the point stream and converts
// emitted points to block units.
// ----------------------------------------------------------------------------
// One transaction is taken every cycle while the output does not stall; a
// point with path_last that also causes a thinning result yields two results
// and holds the decision stage until both are issued, since the point stage
// issues at most one result per cycle. A result passes the input register,
// decision register, multiply register and result register in that order.
module toolpath_height_clamp_thinning #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [hctn_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [hctn_pkg::VAL_BITS-1:0]        csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [COORD_BITS-1:0]         req_tex_x,
   input  logic signed [COORD_BITS-1:0]         req_tex_y,
   input  logic signed [hctn_pkg::VAL_BITS-1:0] req_map_height,
   input  logic                                 req_map_valid,
   input  logic                                 req_path_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [hctn_pkg::VAL_BITS-1:0] rsp_out_x,
   output logic signed [hctn_pkg::VAL_BITS-1:0] rsp_out_z,
   output logic signed [hctn_pkg::VAL_BITS-1:0] rsp_out_height,
   output logic                                 rsp_item_last,
   output logic                                 rsp_path_end
);
   import hctn_pkg::*;

   localparam logic [TOL_BITS-1:0] TOL_RESET =
      TOL_BITS'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
   localparam logic [VAL_BITS-1:0] SCALE_RESET = VAL_BITS'(64'd1 << FRAC_BITS);
   localparam int SUM_BITS = VAL_BITS + 2;

   logic signed [VAL_BITS-1:0] base_ff, off_x_ff, off_y_ff;
   logic [TOL_BITS-1:0]        tol_ff;
   logic [VAL_BITS-1:0]        scl_x_ff, scl_y_ff;

   logic                         s1_v_ff, s1_last_ff, s1_take;
   logic signed [COORD_BITS-1:0] s1_tx_ff, s1_ty_ff;
   logic signed [VAL_BITS-1:0]   s1_h_ff, h_in;
   logic signed [SUM_BITS-1:0]   raised;
   logic signed [VAL_BITS-1:0]   raised_sat;

   logic                         pt_valid, pt_ready;
   logic signed [COORD_BITS-1:0] pt_tx, pt_ty;
   logic signed [VAL_BITS-1:0]   pt_height;
   pt_flags_type                 pt_flags;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         tol_ff   <= TOL_RESET;
         scl_x_ff <= SCALE_RESET;
         off_x_ff <= '0;
         scl_y_ff <= SCALE_RESET;
         off_y_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BASE_HEIGHT: base_ff  <= csr_wdata;
            CSR_TOLERANCE:   tol_ff   <= csr_wdata[TOL_BITS-1:0];
            CSR_SCALE_X:     scl_x_ff <= csr_wdata;
            CSR_OFFSET_X:    off_x_ff <= csr_wdata;
            CSR_SCALE_Y:     scl_y_ff <= csr_wdata;
            CSR_OFFSET_Y:    off_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamped point height
   always_comb begin
      raised = SUM_BITS'(req_map_height) + $signed({2'b00, tol_ff, 1'b0});
      if (raised[SUM_BITS-1:VAL_BITS-1] == {(SUM_BITS-VAL_BITS+1){raised[SUM_BITS-1]}}) begin
         raised_sat = raised[VAL_BITS-1:0];
      end else if (raised[SUM_BITS-1]) begin
         raised_sat = {1'b1, {(VAL_BITS-1){1'b0}}};
      end else begin
         raised_sat = {1'b0, {(VAL_BITS-1){1'b1}}};
      end
      h_in = (req_map_valid && (raised_sat > base_ff)) ? raised_sat : base_ff;
   end

   assign req_ready = !s1_v_ff || s1_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (req_ready) begin
         s1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_tx_ff   <= req_tex_x;
         s1_ty_ff   <= req_tex_y;
         s1_h_ff    <= h_in;
         s1_last_ff <= req_path_last;
      end
   end

   hctn_decide #(
      .COORD_BITS (COORD_BITS)
   ) u_decide (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s1_v_ff),
      .in_take     (s1_take),
      .in_tx       (s1_tx_ff),
      .in_ty       (s1_ty_ff),
      .in_height   (s1_h_ff),
      .in_last     (s1_last_ff),
      .base_height (base_ff),
      .tolerance   (tol_ff),
      .pt_valid    (pt_valid),
      .pt_ready    (pt_ready),
      .pt_tx       (pt_tx),
      .pt_ty       (pt_ty),
      .pt_height   (pt_height),
      .pt_flags    (pt_flags)
   );

   hctn_xform #(
      .COORD_BITS (COORD_BITS)
   ) u_xform (
      .clock          (clock),
      .reset          (reset),
      .pt_valid       (pt_valid),
      .pt_ready       (pt_ready),
      .pt_tx          (pt_tx),
      .pt_ty          (pt_ty),
      .pt_height      (pt_height),
      .pt_flags       (pt_flags),
      .scale_x        (scl_x_ff),
      .offset_x       (off_x_ff),
      .scale_y        (scl_y_ff),
      .offset_y       (off_y_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_z      (rsp_out_z),
      .rsp_out_height (rsp_out_height),
      .rsp_item_last  (rsp_item_last),
      .rsp_path_end   (rsp_path_end)
   );

endmodule
